// ----- hdl/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared constants and codes for the slot free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam int IDX_W     = 7;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int SIZE_W    = 16;
  localparam int ELSZ_W    = 8;
  localparam int BOFF_W    = 16;
  localparam int ELEM_W    = 16;
  localparam int OFFS_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam func_t FN_ALLOC       = 2'd0;
  localparam func_t FN_RELEASE     = 2'd1;
  localparam func_t FN_RELEASE_ALL = 2'd2;
  localparam func_t FN_LOCATE      = 2'd3;

  localparam status_t ST_OK           = 3'd0;
  localparam status_t ST_NONE_FREE    = 3'd1;
  localparam status_t ST_ALREADY_FREE = 3'd2;
  localparam status_t ST_OUT_OF_RANGE = 3'd3;
  localparam status_t ST_NOT_ALLOC    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SETS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE = 2'd2;

  localparam logic [IDX_W-1:0]  MAX_SETS_RST     = 7'd64;
  localparam logic [SIZE_W-1:0] SET_SIZE_RST     = 16'd256;
  localparam logic [ELSZ_W-1:0] ELEMENT_SIZE_RST = 8'd32;

endpackage

// ----- hdl/sfla_ram.sv -----
// ----------------------------------------------------------------------------
// sfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sfla_offset.sv -----
// ----------------------------------------------------------------------------
// sfla_offset
// Descriptor byte offset: registered products, then one three-input add.
// ----------------------------------------------------------------------------
module sfla_offset (
  input  logic                          clk,
  input  logic                          load,
  input  logic [sfla_pkg::IDX_W-1:0]    slot_index,
  input  logic [sfla_pkg::SIZE_W-1:0]   set_size,
  input  logic [sfla_pkg::BOFF_W-1:0]   binding_offset,
  input  logic [sfla_pkg::ELEM_W-1:0]   array_element,
  input  logic [sfla_pkg::ELSZ_W-1:0]   element_size,
  output logic [sfla_pkg::OFFS_W-1:0]   offset
);
  import sfla_pkg::*;

  localparam int PA_W = IDX_W + SIZE_W;
  localparam int PB_W = ELEM_W + ELSZ_W;

  logic [PA_W-1:0]   prod_set;
  logic [PB_W-1:0]   prod_elem;
  logic [BOFF_W-1:0] boff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_set  <= PA_W'(slot_index) * PA_W'(set_size);
      prod_elem <= PB_W'(array_element) * PB_W'(element_size);
      boff      <= binding_offset;
    end
  end

  assign offset = OFFS_W'(prod_set) + OFFS_W'(prod_elem) + OFFS_W'(boff);

endmodule

// ----- hdl/slot_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_free_list_allocator
// Hands out set indices from a LIFO free stack kept in RAM, tracks one
// allocated bit per slot and computes descriptor byte offsets.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | func, slot_index, binding_offset,
//          |                       | array_element
//  out     | out_valid / out_stall | status, granted_index, byte_offset
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  every operation has an accept cycle that issues the stack and map reads
//  and an execute cycle that uses the registered read data and writes back
//  release-all clears the per-entry valid bits: entries fall back to the
//  refill pattern, so there is no clearing pass after reset
//  a result waiting in the output register does not block the next accept;
//  the execute cycle holds while the output register is full and stalled
//  reset is synchronous; the stack holds 63 down to 0 with 0 on top
// ----------------------------------------------------------------------------
module slot_free_list_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sfla_pkg::FUNC_W-1:0]       func,
  input  logic [sfla_pkg::IDX_W-1:0]        slot_index,
  input  logic [sfla_pkg::BOFF_W-1:0]       binding_offset,
  input  logic [sfla_pkg::ELEM_W-1:0]       array_element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfla_pkg::STATUS_W-1:0]     status,
  output logic [sfla_pkg::SLOT_W-1:0]       granted_index,
  output logic [sfla_pkg::OFFS_W-1:0]       byte_offset,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfla_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import sfla_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;

  // configuration
  logic [IDX_W-1:0]  max_sets;
  logic [SIZE_W-1:0] set_size;
  logic [ELSZ_W-1:0] element_size;

  // latched item
  func_t            func_q;
  logic [IDX_W-1:0] slot_q;

  // stack and map control state
  cnt_t                 cnt;
  cnt_t                 cnt_next;
  logic                 ascending;
  logic [MAX_SLOTS-1:0] stk_valid;
  logic [MAX_SLOTS-1:0] alloc_valid;

  // memory ports
  logic  stk_we;
  slot_t stk_waddr;
  slot_t stk_wdata;
  slot_t stk_raddr;
  slot_t stk_q;
  logic  alloc_we;
  slot_t alloc_waddr;
  logic  alloc_wdata;
  slot_t alloc_raddr;
  logic  alloc_q;

  // execute results
  logic               in_accept;
  logic               done;
  logic               refill;
  cnt_t               active;
  slot_t              top_idx;
  slot_t              top_val;
  logic               in_range;
  logic               alloc_bit;
  logic [OFFS_W-1:0]  offset;
  status_t            res_status;
  slot_t              res_granted;
  logic [OFFS_W-1:0]  res_offset;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign done      = (state == ST_EXEC) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sets     <= MAX_SETS_RST;
      set_size     <= SET_SIZE_RST;
      element_size <= ELEMENT_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_SETS:     max_sets     <= cfg_data[IDX_W-1:0];
        REG_SET_SIZE:     set_size     <= cfg_data[SIZE_W-1:0];
        REG_ELEMENT_SIZE: element_size <= cfg_data[ELSZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign active = (max_sets > IDX_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(max_sets);

  // the top of stack address only moves when an item completes
  assign top_idx     = SLOT_W'(cnt - CNT_W'(1));
  assign stk_raddr   = top_idx;
  assign alloc_raddr = (state == ST_IDLE) ? slot_index[SLOT_W-1:0] : slot_q[SLOT_W-1:0];

  sfla_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  sfla_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_alloc_map (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (alloc_waddr),
    .wdata (alloc_wdata),
    .raddr (alloc_raddr),
    .rdata (alloc_q)
  );

  sfla_offset u_offset (
    .clk            (clk),
    .load           (in_accept),
    .slot_index     (slot_index),
    .set_size       (set_size),
    .binding_offset (binding_offset),
    .array_element  (array_element),
    .element_size   (element_size),
    .offset         (offset)
  );

  // an unwritten stack entry reads as the last refill pattern
  always_comb begin
    if (stk_valid[top_idx]) begin
      top_val = stk_q;
    end else if (ascending) begin
      top_val = top_idx;
    end else begin
      top_val = SLOT_W'(MAX_SLOTS - 1) - top_idx;
    end
  end

  assign in_range  = CNT_W'(slot_q) < active;
  assign alloc_bit = alloc_valid[slot_q[SLOT_W-1:0]] & alloc_q;

  always_comb begin
    cnt_next    = cnt;
    refill      = 1'b0;
    stk_we      = 1'b0;
    stk_waddr   = cnt[SLOT_W-1:0];
    stk_wdata   = slot_q[SLOT_W-1:0];
    alloc_we    = 1'b0;
    alloc_waddr = slot_q[SLOT_W-1:0];
    alloc_wdata = 1'b0;
    res_status  = ST_OK;
    res_granted = '0;
    res_offset  = '0;
    case (func_q)
      FN_ALLOC: begin
        if (cnt == '0) begin
          res_status = ST_NONE_FREE;
        end else begin
          cnt_next    = cnt - CNT_W'(1);
          alloc_we    = done;
          alloc_waddr = top_val;
          alloc_wdata = 1'b1;
          res_granted = top_val;
        end
      end
      FN_RELEASE: begin
        if (!in_range) begin
          res_status = ST_OUT_OF_RANGE;
        end else if (!alloc_bit) begin
          res_status = ST_ALREADY_FREE;
        end else if (cnt < CNT_W'(MAX_SLOTS)) begin
          cnt_next = cnt + CNT_W'(1);
          stk_we   = done;
          alloc_we = done;
        end
      end
      FN_RELEASE_ALL: begin
        cnt_next = active;
        refill   = 1'b1;
      end
      FN_LOCATE: begin
        if (!in_range) begin
          res_status = ST_OUT_OF_RANGE;
        end else if (!alloc_bit) begin
          res_status = ST_NOT_ALLOC;
        end else begin
          res_offset = offset;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= CNT_W'(MAX_SLOTS);
      ascending   <= 1'b0;
      stk_valid   <= '0;
      alloc_valid <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state <= ST_IDLE;
            cnt   <= cnt_next;
            if (refill) begin
              ascending   <= 1'b1;
              stk_valid   <= '0;
              alloc_valid <= '0;
            end else begin
              if (stk_we) begin
                stk_valid[stk_waddr] <= 1'b1;
              end
              if (alloc_we) begin
                alloc_valid[alloc_waddr] <= 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_q <= func;
      slot_q <= slot_index;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status        <= res_status;
      granted_index <= res_granted;
      byte_offset   <= res_offset;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_SLOTS))
    else $error("free stack count above slot count");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_EXEC)
    else $error("accepted beat did not enter execute");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EXEC)
    else $error("result appeared without an execute cycle");

  a_refill_count: assert property (@(posedge clk) disable iff (rst)
    (done && refill) |=> cnt == $past(active))
    else $error("release-all did not restore the stack count");

endmodule

// ----- tb/slot_free_list_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_free_list_allocator_tb
// Drives allocate, release, release-all and locate requests into the slot
// allocator under random idling and one long output hold-off. A tracker keeps
// its own copy of the free stack, the allocated bits and the registers,
// predicts each reply and compares the replies in order, field by field.
// ----------------------------------------------------------------------------
import sfla_pkg::*;

typedef struct packed {
  status_t             st;
  slot_t               gi;
  logic [OFFS_W-1:0]   off;
} reply_t;

class alloc_tracker;
  slot_t             free_stack [MAX_SLOTS];
  int unsigned       stack_count;
  bit                allocated [MAX_SLOTS];
  logic [IDX_W-1:0]  max_sets;
  logic [SIZE_W-1:0] set_size;
  logic [ELSZ_W-1:0] element_size;
  reply_t            replies_due [$];
  int                errors;

  function int unsigned active_slots();
    return (max_sets > MAX_SLOTS) ? MAX_SLOTS : max_sets;
  endfunction

  function void refill(bit ascending);
    int unsigned n;
    n = active_slots();
    for (int i = 0; i < n; i++)
      free_stack[i] = slot_t'(ascending ? i : n - 1 - i);
    stack_count = n;
    for (int i = 0; i < MAX_SLOTS; i++) allocated[i] = 1'b0;
  endfunction

  function void reset_state();
    max_sets     = MAX_SETS_RST;
    set_size     = SET_SIZE_RST;
    element_size = ELEMENT_SIZE_RST;
    errors       = 0;
    refill(1'b0);
  endfunction

  function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_MAX_SETS:     max_sets = data[IDX_W-1:0];
      REG_SET_SIZE:     set_size = data[SIZE_W-1:0];
      REG_ELEMENT_SIZE: element_size = data[ELSZ_W-1:0];
      default: ;
    endcase
  endfunction

  // predict the reply to one accepted request and update the stack
  function void note_request(func_t f, logic [IDX_W-1:0] slot,
                             logic [BOFF_W-1:0] boff, logic [ELEM_W-1:0] elem);
    int unsigned n;
    slot_t       idx;
    reply_t      r;
    n = active_slots();
    r = '0;
    case (f)
      FN_ALLOC: begin
        if (stack_count == 0 || stack_count > MAX_SLOTS) begin
          r.st = ST_NONE_FREE;
        end else begin
          stack_count--;
          idx = free_stack[stack_count];
          allocated[idx] = 1'b1;
          r.gi = idx;
        end
      end
      FN_RELEASE: begin
        if (slot >= n) begin
          r.st = ST_OUT_OF_RANGE;
        end else if (!allocated[slot[SLOT_W-1:0]]) begin
          r.st = ST_ALREADY_FREE;
        end else if (stack_count < MAX_SLOTS) begin
          free_stack[stack_count] = slot[SLOT_W-1:0];
          stack_count++;
          allocated[slot[SLOT_W-1:0]] = 1'b0;
        end
      end
      FN_RELEASE_ALL: refill(1'b1);
      default: begin
        if (slot >= n) r.st = ST_OUT_OF_RANGE;
        else if (!allocated[slot[SLOT_W-1:0]]) r.st = ST_NOT_ALLOC;
        else r.off = slot * set_size + boff + elem * element_size;
      end
    endcase
    replies_due = {replies_due, r};
  endfunction

  function void check_reply(status_t st, slot_t gi, logic [OFFS_W-1:0] off);
    reply_t e;
    if (replies_due.size() == 0) begin
      $error("reply with none pending: status %0d index %0d offset 0x%0h", st, gi, off);
      errors++;
      return;
    end
    e = replies_due.pop_front();
    if (st !== e.st) begin
      $error("status mismatch: expected %0d, actual %0d", e.st, st);
      errors++;
    end
    if (gi !== e.gi) begin
      $error("granted_index mismatch: expected %0d, actual %0d", e.gi, gi);
      errors++;
    end
    if (off !== e.off) begin
      $error("byte_offset mismatch: expected 0x%0h, actual 0x%0h", e.off, off);
      errors++;
    end
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  // a random slot that is allocated and in range, or -1
  function int pick_allocated();
    int cand [$];
    for (int i = 0; i < MAX_SLOTS; i++)
      if (allocated[i] && i < active_slots()) cand = {cand, i};
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction
endclass

module slot_free_list_allocator_tb;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func;
  logic [IDX_W-1:0]     slot_index;
  logic [BOFF_W-1:0]    binding_offset;
  logic [ELEM_W-1:0]    array_element;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    granted_index;
  logic [OFFS_W-1:0]    byte_offset;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  alloc_tracker tracker;
  int           sent;
  int           taken;

  slot_free_list_allocator i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .slot_index     (slot_index),
    .binding_offset (binding_offset),
    .array_element  (array_element),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_index  (granted_index),
    .byte_offset    (byte_offset),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input func_t f, input logic [IDX_W-1:0] s,
                           input logic [BOFF_W-1:0] b, input logic [ELEM_W-1:0] e);
    // random gap, none inside the quiet stretch
    if (!(sent >= 500 && sent < 700) && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_valid       <= 1'b1;
    func           <= f;
    slot_index     <= s;
    binding_offset <= b;
    array_element  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(f, s, b, e);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [IDX_W-1:0] ms, input logic [SIZE_W-1:0] ss,
                              input logic [ELSZ_W-1:0] es);
    logic [CFG_IDX_W-1:0] regs [3];
    logic [CFG_DAT_W-1:0] vals [3];
    regs[0] = REG_MAX_SETS;
    regs[1] = REG_SET_SIZE;
    regs[2] = REG_ELEMENT_SIZE;
    vals[0] = CFG_DAT_W'(ms);
    vals[1] = ss;
    vals[2] = CFG_DAT_W'(es);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.note_config(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // output side: checks every reply beat, idles at random, holds off once
  initial begin : reply_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        tracker.check_reply(status, granted_index, byte_offset);
        taken++;
      end
      if (!held && taken >= 300) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (taken >= 700 && taken < 900) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 26);
      end
    end
  end

  initial begin : stimulus
    int                 r;
    int                 pick;
    logic [IDX_W-1:0]   ms;
    logic [SIZE_W-1:0]  ss;
    logic [ELSZ_W-1:0]  es;
    logic [IDX_W-1:0]   slot;
    func_t              f;

    tracker = new();
    tracker.reset_state();
    sent           = 0;
    taken          = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = FN_ALLOC;
    slot_index     = '0;
    binding_offset = '0;
    array_element  = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_MAX_SETS;
    cfg_data       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset stack order, lifo reuse, range and allocation checks
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);
    send_item(FN_ALLOC, 7'd127, 16'hFFFF, 16'hFFFF);
    send_item(FN_LOCATE, 7'd1, 16'hFFFF, 16'hFFFF);
    send_item(FN_LOCATE, 7'd5, 16'd1, 16'd1);
    send_item(FN_LOCATE, 7'd64, 16'd0, 16'd0);
    send_item(FN_RELEASE, 7'd127, 16'd0, 16'd0);
    send_item(FN_RELEASE, 7'd5, 16'd0, 16'd0);
    send_item(FN_RELEASE, 7'd1, 16'd0, 16'd0);
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);
    send_item(FN_RELEASE_ALL, 7'd0, 16'd0, 16'd0);
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);

    // single slot with the largest sizes, empty stack
    drain();
    write_config(7'd1, 16'hFFFF, 8'hFF);
    send_item(FN_RELEASE_ALL, 7'd0, 16'd0, 16'd0);
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);
    send_item(FN_LOCATE, 7'd0, 16'hFFFF, 16'hFFFF);
    send_item(FN_RELEASE, 7'd1, 16'd0, 16'd0);
    send_item(FN_RELEASE, 7'd0, 16'd0, 16'd0);

    // shrink without release-all: a stale index is still granted
    drain();
    write_config(7'd4, 16'd0, 8'd0);
    send_item(FN_RELEASE_ALL, 7'd0, 16'd0, 16'd0);
    drain();
    write_config(7'd2, 16'd0, 8'd0);
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);
    send_item(FN_LOCATE, 7'd3, 16'd0, 16'd0);

    // grow without release-all: slots never handed out are already free
    drain();
    write_config(7'd8, 16'd16, 8'd8);
    send_item(FN_RELEASE, 7'd6, 16'd0, 16'd0);

    // no slots at all, then a count above the slot limit
    drain();
    write_config(7'd0, 16'd16, 8'd8);
    send_item(FN_RELEASE_ALL, 7'd0, 16'd0, 16'd0);
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);
    send_item(FN_LOCATE, 7'd0, 16'd0, 16'd0);
    drain();
    write_config(7'd127, 16'd16, 8'd8);
    send_item(FN_RELEASE_ALL, 7'd0, 16'd0, 16'd0);
    send_item(FN_ALLOC, 7'd0, 16'd0, 16'd0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          ms = 7'd64; ss = 16'd0; es = 8'd0;
        end
        1: begin
          ms = 7'd1; ss = 16'hFFFF; es = 8'hFF;
        end
        default: begin
          ms = $urandom_range(1) ? 7'($urandom_range(2, 8)) : 7'($urandom_range(1, 64));
          ss = 16'($urandom);
          es = 8'($urandom);
        end
      endcase
      drain();
      write_config(ms, ss, es);
      // one phase keeps the old stack to reach stale entries
      if (p != 3) send_item(FN_RELEASE_ALL, 7'($urandom), 16'($urandom), 16'($urandom));
      for (int k = 0; k < 150; k++) begin
        r    = $urandom_range(99);
        pick = tracker.pick_allocated();
        if (pick < 0 || $urandom_range(99) < 20)
          slot = $urandom_range(1) ? 7'($urandom) : 7'($urandom_range(0, ms));
        else
          slot = 7'(pick);
        if (r < 35)      f = FN_ALLOC;
        else if (r < 65) f = FN_RELEASE;
        else if (r < 96) f = FN_LOCATE;
        else             f = FN_RELEASE_ALL;
        send_item(f, slot, 16'($urandom), 16'($urandom));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0)
      $error("%0d replies never arrived", tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
